// ===== hdl/bdq_pkg.sv =====
// shared types and codes for the bounded deque with search
package bdq_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CMD_W  = 3;
   localparam int unsigned STAT_W = 2;

   // command codes carried on req_tuser
   localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_LIST_ALL   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_LIST_EVEN  = 3'd7;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

   // cell operations
   localparam logic [1:0] CELL_HOLD = 2'd0;
   localparam logic [1:0] CELL_SHR  = 2'd1;
   localparam logic [1:0] CELL_SHL  = 2'd2;
   localparam logic [1:0] CELL_LOAD = 2'd3;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic [1:0]        op;
      logic [DATA_W-1:0] ins_value;
   } cell_ctrl_type;

endpackage

// ===== hdl/bdq_cell.sv =====
// one storage cell of the deque chain
module bdq_cell
   import bdq_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic              sel,
   input  logic [DATA_W-1:0] left_data,
   input  logic [DATA_W-1:0] right_data,
   output logic [DATA_W-1:0] data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // pick the next value from a neighbor, the insert value or self
   always_comb begin
      data_in = data_ff;
      unique case (ctrl.op)
         CELL_HOLD: data_in = data_ff;
         CELL_SHR:  data_in = left_data;
         CELL_SHL:  data_in = right_data;
         CELL_LOAD: data_in = sel ? ctrl.ins_value : data_ff;
         default:   data_in = data_ff;
      endcase
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== hdl/bounded_deque_with_search_unit.sv =====
// top level of the bounded deque with linear search
//
// Commands enter on the req_ stream: req_tuser carries the command code,
// req_tdata the value to push or to search for. Results leave on the rsp_
// stream, one beat per result; rsp_tlast marks the final beat of a command.
// Entries sit in a chain of DEPTH cells, the front entry in the first cell.
// Push and pop front shift or load the chain in the accept cycle, pop back
// only lowers the count; each gives its single result beat in the next cycle.
// Search and listings rotate the whole chain through the first cell, one
// step a cycle while the receiver keeps up, for DEPTH steps, which puts it
// back in order; the final beat follows once the output register is free.
// A listing holds one entry back so the last beat can be marked.
// A new command is accepted only when the previous one is finished and the
// output register is free or being drained. When the receiver stalls, the
// output register holds its beat and a listing walk with a beat to give waits until it is taken.
// Reset empties the list and the output register; cell contents are not
// cleared and are read only after being written.
module bounded_deque_with_search_unit
   import bdq_pkg::*;
#(
   parameter int unsigned DEPTH = 64
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,  // [31:0] value
   input  logic [CMD_W-1:0]  req_tuser,  // [2:0] command
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,  // [31:0] result_value
   output logic [3:0]        rsp_tuser,  // [0] holds_item, [1] found, [3:2] status
   output logic              rsp_tlast   // last_of_run
);

   localparam int unsigned IDX_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [DATA_W-1:0]  key_ff, key_in;
   logic               hit_ff, hit_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [DATA_W-1:0]  pend_ff, pend_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_value_ff, rsp_value_in;
   logic               rsp_holds_ff, rsp_holds_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               accept;
   logic               is_full;
   logic               is_empty;
   logic [DATA_W-1:0]  head;
   logic               active;
   logic               qualifies;
   logic               listing;
   logic               advance;
   cell_ctrl_type      ctrl;
   logic [DATA_W-1:0]  cell_data [DEPTH];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign is_full    = (count_ff == CNT_W'(DEPTH));
   assign is_empty   = (count_ff == '0);

   // walk step view of the chain head
   assign head      = cell_data[0];
   assign active    = (step_ff < count_ff);
   assign listing   = (cmd_ff == CMD_LIST_ALL) || (cmd_ff == CMD_LIST_EVEN);
   assign qualifies = active && listing && ((cmd_ff == CMD_LIST_ALL) || !head[0]);
   assign advance   = (state_ff == ST_WALK) && !(qualifies && pend_valid_ff && !out_free);

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_w;
      logic [DATA_W-1:0] right_w;
      logic              sel_w;
      if (i == 0) begin : g_first
         assign left_w = ctrl.ins_value;
      end else begin : g_rest
         assign left_w = cell_data[i-1];
      end
      assign right_w = cell_data[(i + 1) % DEPTH];
      assign sel_w   = (count_ff[IDX_W-1:0] == IDX_W'(i));
      bdq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .sel        (sel_w),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[i])
      );
   end

   // control, count and result selection
   always_comb begin
      ctrl.op        = CELL_HOLD;
      ctrl.ins_value = req_tdata;
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      hit_in         = hit_ff;
      pend_valid_in  = pend_valid_ff;
      pend_in        = pend_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_value_in   = rsp_value_ff;
      rsp_holds_in   = rsp_holds_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_holds_in  = 1'b0;
               rsp_found_in  = 1'b0;
               rsp_status_in = STAT_OK;
               rsp_last_in   = 1'b1;
               unique case (req_tuser)
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        ctrl.op  = (req_tuser == CMD_PUSH_FRONT) ? CELL_SHR : CELL_LOAD;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        if (req_tuser == CMD_POP_FRONT) begin
                           ctrl.op = CELL_SHL;
                        end
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     // search and listings walk the chain
                     rsp_valid_in  = 1'b0;
                     state_in      = ST_WALK;
                     cmd_in        = req_tuser;
                     key_in        = req_tdata;
                     step_in       = '0;
                     hit_in        = 1'b0;
                     pend_valid_in = 1'b0;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (advance) begin
               ctrl.op = CELL_SHL;
               step_in = step_ff + CNT_W'(1);
               if (step_ff == CNT_W'(DEPTH - 1)) begin
                  state_in = ST_DONE;
               end
               if (active && (cmd_ff == CMD_SEARCH) && (head == key_ff)) begin
                  hit_in = 1'b1;
               end
               if (qualifies) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = pend_ff;
                     rsp_holds_in  = 1'b1;
                     rsp_found_in  = 1'b0;
                     rsp_status_in = STAT_OK;
                     rsp_last_in   = 1'b0;
                  end
                  pend_in       = head;
                  pend_valid_in = 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               if (cmd_ff == CMD_SEARCH) begin
                  rsp_value_in  = '0;
                  rsp_holds_in  = 1'b0;
                  rsp_found_in  = hit_ff;
                  rsp_status_in = is_empty ? STAT_EMPTY : STAT_OK;
               end else if (pend_valid_ff) begin
                  rsp_value_in  = pend_ff;
                  rsp_holds_in  = 1'b1;
                  rsp_found_in  = 1'b0;
                  rsp_status_in = STAT_OK;
               end else begin
                  rsp_value_in  = '0;
                  rsp_holds_in  = 1'b0;
                  rsp_found_in  = 1'b0;
                  rsp_status_in = STAT_EMPTY;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // walk and result payload registers
   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      hit_ff        <= hit_in;
      pend_valid_ff <= pend_valid_in;
      pend_ff       <= pend_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_holds_ff  <= rsp_holds_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_found_ff, rsp_holds_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
